// ----- hw/rtl/sha_pkg.sv -----
// Shared types and constants for the SHA-256 stream hasher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FINAL,
        ST_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_byte;
        logic       pad_byte;
        logic [7:0] pad_value;
        logic       pad_length;
        logic       comp_start;
        logic       comp_round;
        logic       comp_finish;
        logic       hash_reset;
        logic       count_clear;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] fill;
        logic [5:0] round;
    } dp_status_t;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam int unsigned LEN_POS = 56;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] v;
        case (i)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage
`default_nettype wire

// ----- hw/rtl/sha_datapath.sv -----
// Datapath: block buffer, bit counter, message schedule, round logic, hash words.
// Depends on sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sha_pkg::ctrl_cmd_t cmd,
    input  wire logic [7:0]         in_byte,
    input  wire logic [2:0]         rd_index,
    output logic [31:0]             rd_word,
    output sha_pkg::dp_status_t     status
);
    import sha_pkg::*;

    logic [31:0] blk_reg [16];
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [5:0]  round_reg;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Fill pointer and message bit count.
    always_comb begin
        fill_next = fill_reg;
        bits_next = bits_reg;
        if (cmd.count_clear) begin
            fill_next = '0;
            bits_next = '0;
        end else if (cmd.load_byte) begin
            fill_next = fill_reg + 6'd1;
            bits_next = bits_reg + 64'd8;
        end else if (cmd.pad_byte) begin
            fill_next = fill_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            bits_reg <= '0;
        end else begin
            fill_reg <= fill_next;
            bits_reg <= bits_next;
        end
    end

    // Byte writes into the block buffer; the length fills the last eight bytes.
    logic [7:0] pad_data;
    always_comb begin
        pad_data = cmd.pad_value;
        if (cmd.pad_length)
            pad_data = bits_reg[8 * (7 - int'(fill_reg[2:0])) +: 8];
    end

    // The buffer holds the block as sixteen big-endian words.
    always_ff @(posedge aclk) begin
        if (cmd.load_byte)
            blk_reg[fill_reg[5:2]][8 * (3 - int'(fill_reg[1:0])) +: 8] <= in_byte;
        else if (cmd.pad_byte)
            blk_reg[fill_reg[5:2]][8 * (3 - int'(fill_reg[1:0])) +: 8] <= pad_data;
    end

    // Round logic: schedule word and one compression round per cycle.
    logic [31:0] w_cur, t1, t2, s0, s1, w2, w15;
    always_comb begin
        w2  = w_reg[4'(round_reg - 6'd2)];
        w15 = w_reg[4'(round_reg - 6'd15)];
        s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        if (round_reg < 6'd16)
            w_cur = blk_reg[round_reg[3:0]];
        else
            w_cur = s1 + w_reg[4'(round_reg - 6'd7)] + s0 + w_reg[round_reg[3:0]];
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[round_reg] + w_cur;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (cmd.comp_start) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
        end else if (cmd.comp_round) begin
            w_reg[round_reg[3:0]] <= w_cur;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // Round counter.
    always_ff @(posedge aclk) begin
        if (!aresetn)
            round_reg <= '0;
        else if (cmd.comp_start)
            round_reg <= '0;
        else if (cmd.comp_round)
            round_reg <= round_reg + 6'd1;
    end

    // Hash words: initial values, or accumulate after a block.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.hash_reset) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= init_hash(3'(i));
        end else if (cmd.comp_finish) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
        end
    end

    assign rd_word = h_reg[rd_index];
    assign status.fill = fill_reg;
    assign status.round = round_reg;

    // A data byte and a pad byte are never written in the same cycle.
    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load_byte && cmd.pad_byte)) else $error("two buffer writes");
    // Rounds advance one at a time.
    a_round_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.comp_round && !cmd.comp_start |=> round_reg == $past(round_reg) + 6'd1)
        else $error("round skipped");
    // The buffer is never written while a block is compressed.
    a_no_write_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.comp_round |-> !cmd.load_byte && !cmd.pad_byte) else $error("write in round");

endmodule
`default_nettype wire

// ----- hw/rtl/sha_controller.sv -----
// Controller: sequences byte loads, padding, compression and digest output.
// Depends on sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_controller (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_fire,
    input  wire logic                in_end,
    input  wire logic                out_fire,
    input  wire sha_pkg::dp_status_t status,
    output sha_pkg::ctrl_cmd_t       cmd,
    output logic                     in_ready,
    output logic                     out_valid,
    output logic [2:0]               out_index
);
    import sha_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        mark_reg, mark_next;    // 0x80 already placed
    logic        final_reg, final_next;  // current block carries the length
    logic [2:0]  idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mark_reg  <= 1'b0;
            final_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            mark_reg  <= mark_next;
            final_reg <= final_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        mark_next  = mark_reg;
        final_next = final_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_fire && !in_end) begin
                    cmd.load_byte = 1'b1;
                    if (status.fill == 6'd63) begin
                        cmd.comp_start = 1'b1;
                        final_next = 1'b0;
                        state_next = ST_COMP;
                    end
                end else if (in_fire) begin
                    mark_next  = 1'b0;
                    state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                cmd.pad_byte   = 1'b1;
                cmd.pad_value  = mark_reg ? 8'h00 : PAD_MARK;
                // The last eight bytes of the block that carries the length hold it.
                cmd.pad_length = mark_reg && final_reg && (status.fill >= 6'(LEN_POS));
                mark_next      = 1'b1;
                // Length lands in this block only if the mark left room for it.
                if (!mark_reg) final_next = (status.fill < 6'(LEN_POS));
                if (status.fill == 6'd63) begin
                    cmd.comp_start = 1'b1;
                    state_next = ST_COMP;
                end
            end
            ST_COMP: begin
                cmd.comp_round = 1'b1;
                if (status.round == 6'd63) state_next = ST_FINAL;
            end
            ST_FINAL: begin
                cmd.comp_finish = 1'b1;
                if (!mark_reg) state_next = ST_IDLE;
                else if (final_reg) begin
                    idx_next = '0;
                    state_next = ST_EMIT;
                end else begin
                    // The second padding block always carries the length.
                    final_next = 1'b1;
                    state_next = ST_PAD;
                end
            end
            ST_EMIT: begin
                out_valid = 1'b1;
                if (out_fire) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        cmd.hash_reset  = 1'b1;
                        cmd.count_clear = 1'b1;
                        mark_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_index = idx_reg;

    // Digest words go out only in the emit state.
    a_emit_only: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> state_reg == ST_EMIT) else $error("stray output");
    // Input is refused while a block is compressed.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COMP |-> !in_ready) else $error("ready during rounds");
    // After the last word the hasher returns to idle.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire && idx_reg == 3'd7 |=> state_reg == ST_IDLE) else $error("no restart");

endmodule
`default_nettype wire

// ----- hw/rtl/sha256_stream_hasher_unit.sv -----
// Top level of the SHA-256 stream hasher: stream ports around controller and datapath.
// Depends on sha_pkg, sha_controller and sha_datapath.
`timescale 1ns / 1ps
`default_nettype none
// A data word (tuser 0) is written into the block buffer, and the 64th byte of a block
// starts the compression (one round per cycle in the shared round unit, then
// an accumulate step into the hash words).
// An end word (tuser 1) pads the block one byte per cycle, compresses one or
// two blocks and then offers the eight digest words, one per
// cycle while m_tready is high, index 0 first, tlast on the eighth. No new
// input word is taken until the digest has been delivered.
module sha256_stream_hasher_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic             m_tlast
);
    import sha_pkg::*;

    ctrl_cmd_t   cmd;
    dp_status_t  status;
    logic [2:0]  idx;
    logic [31:0] word;

    sha_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_tvalid && s_tready), .in_end(s_tuser),
        .out_fire(m_tvalid && m_tready), .status(status), .cmd(cmd),
        .in_ready(s_tready), .out_valid(m_tvalid), .out_index(idx)
    );

    sha_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .in_byte(s_tdata),
        .rd_index(idx), .rd_word(word), .status(status)
    );

    assign m_tdata = {5'd0, idx, word};
    assign m_tlast = (idx == 3'd7);

endmodule
`default_nettype wire

// ----- sim/sha256_stream_hasher_unit_tb.sv -----
// Self-checking testbench for the SHA-256 stream hasher unit.
// It feeds byte and end-of-message words, predicts the digests and checks every output word.
// Depends on sha_pkg and the sha256_stream_hasher_unit RTL.
`timescale 1ns / 1ps

class digest_scoreboard;
    logic [31:0] hash_state [8];
    logic [7:0]  block_bytes [64];
    int unsigned fill_count;
    logic [63:0] bit_count;
    logic [39:0] expected_words [$];
    logic        expected_lasts [$];
    int unsigned error_count;

    function new();
        restart();
        error_count = 0;
    endfunction

    function void restart();
        hash_state[0] = 32'h6a09e667; hash_state[1] = 32'hbb67ae85;
        hash_state[2] = 32'h3c6ef372; hash_state[3] = 32'ha54ff53a;
        hash_state[4] = 32'h510e527f; hash_state[5] = 32'h9b05688c;
        hash_state[6] = 32'h1f83d9ab; hash_state[7] = 32'h5be0cd19;
        fill_count = 0;
        bit_count = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of the current block into the hash state.
    function void compress();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, t1, t2, w2, w15;
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                wt = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                      block_bytes[4*t+3]};
            end else begin
                w2 = w[(t-2) & 15];
                w15 = w[(t-15) & 15];
                wt = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + w[(t-7) & 15]
                   + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + w[t & 15];
            end
            w[t & 15] = wt;
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[t] + wt;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endfunction

    // Note an accepted input word and queue any digest words it causes.
    function void note_input(logic is_end, logic [7:0] data);
        int unsigned pos;
        if (!is_end) begin
            block_bytes[fill_count] = data;
            bit_count += 64'd8;
            fill_count = (fill_count + 1) % 64;
            if (fill_count == 0) compress();
            return;
        end
        pos = fill_count;
        block_bytes[pos++] = 8'h80;
        // Tight padding spills the length into a second block.
        if (pos > 56) begin
            while (pos < 64) block_bytes[pos++] = 8'h00;
            compress();
            pos = 0;
        end
        while (pos < 56) block_bytes[pos++] = 8'h00;
        for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_count[63-8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++) begin
            expected_words.push_back({5'd0, 3'(i), hash_state[i]});
            expected_lasts.push_back(i == 7);
        end
        restart();
    endfunction

    function void report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endfunction

    // Check one accepted output word against the oldest expectation.
    function void check_output(logic [39:0] data, logic last);
        logic [39:0] exp_data;
        logic exp_last;
        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", data));
            return;
        end
        exp_data = expected_words.pop_front();
        exp_last = expected_lasts.pop_front();
        if (data[31:0] !== exp_data[31:0])
            report_mismatch($sformatf("digest word %h, expected %h", data[31:0],
                            exp_data[31:0]));
        if (data[34:32] !== exp_data[34:32])
            report_mismatch($sformatf("word index %0d, expected %0d", data[34:32],
                            exp_data[34:32]));
        if (last !== exp_last)
            report_mismatch($sformatf("tlast %b, expected %b", last, exp_last));
    endfunction
endclass

module sha256_stream_hasher_unit_tb;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        long_hold = 1'b0;
    logic        stim_done = 1'b0;

    digest_scoreboard sb = new();

    sha256_stream_hasher_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // Offer one word and hold it until the block takes it; returns at a falling edge.
    task send_word(logic is_end, logic [7:0] data);
        int gap;
        gap = gap_length();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= is_end;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(is_end, data);
        @(negedge aclk);
    endtask

    task send_message(int unsigned len);
        for (int i = 0; i < len; i++) send_word(1'b0, 8'($urandom));
        send_word(1'b1, 8'($urandom));
    endtask

    // Output side: sample at the rising edge, change ready at the falling edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_output(m_tdata, m_tlast);
    end

    initial begin
        int hold;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
            end else begin
                hold = gap_length();
                if (hold == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (hold) @(negedge aclk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        int wait_cycles;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // Directed: empty message, extreme bytes, short messages.
        send_word(1'b1, 8'hff);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hff);
        send_word(1'b1, 8'h00);
        send_message(3);
        send_message(15);
        // Long receiver hold while a message and its digest pile up.
        fork
            begin
                long_hold = 1'b1;
                repeat (400) @(posedge aclk);
                long_hold = 1'b0;
            end
            begin
                send_message(1);
                send_message(2);
            end
        join
        // Random: short messages, lengths around the padding boundaries and across the first block boundary.
        repeat (7) begin
            case ($urandom_range(0, 3))
                0: send_message($urandom_range(0, 8));
                1: send_message($urandom_range(54, 57));
                2: send_message($urandom_range(60, 72));
                default: send_message($urandom_range(9, 40));
            endcase
        end
        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (sb.expected_words.size() != 0 && wait_cycles < 20000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (200) @(posedge aclk);
        if (sb.error_count == 0 && sb.expected_words.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
